### src/mp2a_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the 2-D max pooling block.
// Depends on nothing; the design files use scoped names, the testbench imports it.
package mp2a_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int MAX_WINDOW    = 16;
  localparam int MAX_OUT_COLS  = 1024;
  localparam int MAP_LIMIT     = 1024;
  localparam int OFF_BITS      = $clog2(MAX_WINDOW);
  localparam int SLOT_BITS     = $clog2(MAX_OUT_COLS);
  localparam int POS_BITS      = 10;
  localparam int WIN_REG_BITS  = 5;
  localparam int MAP_REG_BITS  = 11;
  localparam int CFG_DATA_BITS = 11;
  localparam int CFG_IDX_BITS  = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_WINDOW_ROWS = 2'd0,
    REG_WINDOW_COLS = 2'd1,
    REG_IN_ROWS     = 2'd2,
    REG_IN_COLS     = 2'd3
  } cfg_reg_t;

  // One store entry: maximum so far and the winner's offset in the window.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] max_val;
    logic [OFF_BITS-1:0]           off_row;
    logic [OFF_BITS-1:0]           off_col;
  } entry_t;

  // A sample together with its position, as handed to the update stage.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [SLOT_BITS-1:0]          slot;
    logic                          first;
    logic                          emit;
    logic                          map_done;
    logic [POS_BITS-1:0]           row;
    logic [POS_BITS-1:0]           col;
    logic [POS_BITS-1:0]           orow;
    logic [OFF_BITS-1:0]           wro;
    logic [OFF_BITS-1:0]           wco;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] pooled;
    logic [POS_BITS-1:0]           out_row;
    logic [POS_BITS-1:0]           out_col;
    logic [POS_BITS-1:0]           winner_row;
    logic [POS_BITS-1:0]           winner_col;
    logic                          map_done;
  } result_t;

  // Status of the update stage as seen by the top level.
  typedef struct packed {
    logic ready;
    logic fire;
    logic emit;
  } upd_status_t;

  function automatic logic [WIN_REG_BITS-1:0] clamp_window(
    input logic [CFG_DATA_BITS-1:0] v
  );
    logic [WIN_REG_BITS-1:0] w;
    w = v[WIN_REG_BITS-1:0];
    if (w == '0) begin
      return WIN_REG_BITS'(1);
    end else if (w > WIN_REG_BITS'(MAX_WINDOW)) begin
      return WIN_REG_BITS'(MAX_WINDOW);
    end
    return w;
  endfunction

  function automatic logic [MAP_REG_BITS-1:0] clamp_map(
    input logic [CFG_DATA_BITS-1:0] v
  );
    logic [MAP_REG_BITS-1:0] m;
    m = v[MAP_REG_BITS-1:0];
    if (m == '0) begin
      return MAP_REG_BITS'(1);
    end else if (m > MAP_REG_BITS'(MAP_LIMIT)) begin
      return MAP_REG_BITS'(MAP_LIMIT);
    end
    return m;
  endfunction

endpackage

### src/mp2a_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for samples in and pooled results out.
// Depends on mp2a_pkg for field widths.
interface mp2a_sample_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [mp2a_pkg::SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface mp2a_result_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [mp2a_pkg::SAMPLE_BITS-1:0] pooled;
  logic [mp2a_pkg::POS_BITS-1:0]           out_row;
  logic [mp2a_pkg::POS_BITS-1:0]           out_col;
  logic [mp2a_pkg::POS_BITS-1:0]           winner_row;
  logic [mp2a_pkg::POS_BITS-1:0]           winner_col;
  logic                                   map_done;

  modport source (output valid, output pooled, output out_row, output out_col,
                  output winner_row, output winner_col, output map_done, input ready);
  modport sink   (input valid, input pooled, input out_row, input out_col,
                  input winner_row, input winner_col, input map_done, output ready);
endinterface

### src/max_pool_2d_argmax.sv
`timescale 1ns / 1ps
// Top level of the streaming 2-D max pooling block with argmax.
// Depends on mp2a_pkg, mp2a_if and mp2a_update.

// Samples of each feature map arrive in raster order on the samples channel,
// maps following one another with no gap, and the block takes one word per
// clock cycle for as long as results are being taken. A pooled result leaves
// on the results channel after the sample that closes its window is accepted:
// the sample is registered with the synchronous read of the per-column store,
// then compared and written back, and the result is then held in an output
// register. The store keeps, for every output column, the running maximum and
// the winner's offset inside the open window; a slot written and read in the
// same cycle is served by forwarding, so back-to-back samples of one window
// need no stall. Within a window the first largest sample wins. Windows
// at the right and bottom edges are clipped. A write on the configuration port
// clamps the value into its legal range and returns the stream to the start
// of a map; writes are meant to happen only while the block is idle. There is
// no clearing pass after reset, as every window opens by writing its slot.
module max_pool_2d_argmax (
  input  logic                                 clk,
  input  logic                                 rst,
  mp2a_sample_if.sink                          samples,
  mp2a_result_if.source                        results,
  input  logic                                 wr_en,
  input  logic [mp2a_pkg::CFG_IDX_BITS-1:0]    wr_index,
  input  logic [mp2a_pkg::CFG_DATA_BITS-1:0]   wr_data
);

  localparam int POS_W = mp2a_pkg::POS_BITS;
  localparam int OFF_W = mp2a_pkg::OFF_BITS;
  localparam int WIN_W = mp2a_pkg::WIN_REG_BITS;
  localparam int MAP_W = mp2a_pkg::MAP_REG_BITS;

  // Configuration, held already clamped.
  logic [WIN_W-1:0] window_rows;
  logic [WIN_W-1:0] window_cols;
  logic [MAP_W-1:0] in_rows;
  logic [MAP_W-1:0] in_cols;

  // Stream position of the next sample.
  logic [POS_W-1:0] row_count;
  logic [POS_W-1:0] col_count;
  logic [OFF_W-1:0] win_row_offset;
  logic [OFF_W-1:0] win_col_offset;
  logic [POS_W-1:0] out_row_count;
  logic [mp2a_pkg::SLOT_BITS-1:0] out_col_count;

  logic last_row, last_col, row_wrap, col_wrap, accept;
  mp2a_pkg::item_t       item;
  mp2a_pkg::upd_status_t status;
  mp2a_pkg::result_t     result;
  mp2a_pkg::result_t     out_reg;
  logic                  out_valid;
  logic                  sink_free;
  logic                  load;

  assign last_row = (MAP_W'(row_count) + MAP_W'(1)) >= in_rows;
  assign last_col = (MAP_W'(col_count) + MAP_W'(1)) >= in_cols;
  assign row_wrap = (WIN_W'(win_row_offset) + WIN_W'(1)) >= window_rows;
  assign col_wrap = (WIN_W'(win_col_offset) + WIN_W'(1)) >= window_cols;

  assign samples.ready = status.ready;
  assign accept        = samples.valid && status.ready;

  always_comb begin
    item.sample   = samples.sample;
    item.slot     = out_col_count;
    item.first    = (win_row_offset == '0) && (win_col_offset == '0);
    item.emit     = (row_wrap || last_row) && (col_wrap || last_col);
    item.map_done = last_row && last_col;
    item.row      = row_count;
    item.col      = col_count;
    item.orow     = out_row_count;
    item.wro      = win_row_offset;
    item.wco      = win_col_offset;
  end

  mp2a_update u_update (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .sink_free (sink_free),
    .status    (status),
    .result    (result)
  );

  // Output register: it frees itself in the cycle the held word is taken.
  assign sink_free = !out_valid || results.ready;
  assign load      = status.fire && status.emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_reg <= result;
    end
  end

  assign results.valid      = out_valid;
  assign results.pooled     = out_reg.pooled;
  assign results.out_row    = out_reg.out_row;
  assign results.out_col    = out_reg.out_col;
  assign results.winner_row = out_reg.winner_row;
  assign results.winner_col = out_reg.winner_col;
  assign results.map_done   = out_reg.map_done;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_rows <= WIN_W'(2);
      window_cols <= WIN_W'(2);
      in_rows     <= MAP_W'(28);
      in_cols     <= MAP_W'(28);
    end else if (wr_en) begin
      unique case (mp2a_pkg::cfg_reg_t'(wr_index))
        mp2a_pkg::REG_WINDOW_ROWS: window_rows <= mp2a_pkg::clamp_window(wr_data);
        mp2a_pkg::REG_WINDOW_COLS: window_cols <= mp2a_pkg::clamp_window(wr_data);
        mp2a_pkg::REG_IN_ROWS:     in_rows     <= mp2a_pkg::clamp_map(wr_data);
        mp2a_pkg::REG_IN_COLS:     in_cols     <= mp2a_pkg::clamp_map(wr_data);
        default: ;
      endcase
    end
  end

  // Stream position counters. The output row and column are counted
  // alongside, so no division by the window size is ever needed.
  always_ff @(posedge clk) begin
    if (rst || wr_en) begin
      row_count      <= '0;
      col_count      <= '0;
      win_row_offset <= '0;
      win_col_offset <= '0;
      out_row_count  <= '0;
      out_col_count  <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_count      <= '0;
        win_col_offset <= '0;
        out_col_count  <= '0;
        if (last_row) begin
          row_count      <= '0;
          win_row_offset <= '0;
          out_row_count  <= '0;
        end else begin
          row_count <= row_count + POS_W'(1);
          if (row_wrap) begin
            win_row_offset <= '0;
            out_row_count  <= out_row_count + POS_W'(1);
          end else begin
            win_row_offset <= win_row_offset + OFF_W'(1);
          end
        end
      end else begin
        col_count <= col_count + POS_W'(1);
        if (col_wrap) begin
          win_col_offset <= '0;
          out_col_count  <= out_col_count + mp2a_pkg::SLOT_BITS'(1);
        end else begin
          win_col_offset <= win_col_offset + OFF_W'(1);
        end
      end
    end
  end

endmodule

### src/mp2a_update.sv
`timescale 1ns / 1ps
// Update stage: per-column window store, read-modify-write and result forming.
// Depends on mp2a_pkg.
module mp2a_update (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  mp2a_pkg::item_t     item,
  input  logic                sink_free,
  output mp2a_pkg::upd_status_t status,
  output mp2a_pkg::result_t   result
);

  localparam int POS_W = mp2a_pkg::POS_BITS;

  mp2a_pkg::entry_t store [mp2a_pkg::MAX_OUT_COLS];

  logic              b_valid;
  mp2a_pkg::item_t   b_item;
  mp2a_pkg::entry_t  rd_data;
  logic              fwd_hit;
  mp2a_pkg::entry_t  fwd_data;
  mp2a_pkg::entry_t  old_entry;
  mp2a_pkg::entry_t  upd;
  logic              fire;

  always_comb begin
    old_entry = fwd_hit ? fwd_data : rd_data;
    if (b_item.first) begin
      upd.max_val = b_item.sample;
      upd.off_row = '0;
      upd.off_col = '0;
    end else if ($signed(b_item.sample) > $signed(old_entry.max_val)) begin
      upd.max_val = b_item.sample;
      upd.off_row = b_item.wro;
      upd.off_col = b_item.wco;
    end else begin
      upd = old_entry;
    end
  end

  assign fire          = b_valid && (!b_item.emit || sink_free);
  assign status.fire   = fire;
  assign status.emit   = b_item.emit;
  assign status.ready  = !b_valid || fire;

  assign result.pooled     = upd.max_val;
  assign result.out_row    = b_item.orow;
  assign result.out_col    = b_item.slot;
  assign result.winner_row = b_item.row - POS_W'(b_item.wro) + POS_W'(upd.off_row);
  assign result.winner_col = b_item.col - POS_W'(b_item.wco) + POS_W'(upd.off_col);
  assign result.map_done   = b_item.map_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= accept || (b_valid && !fire);
    end
  end

  // A read of the slot being written in the same cycle returns the old
  // contents, so the fresh value is kept aside and used instead.
  always_ff @(posedge clk) begin
    if (fire) begin
      store[b_item.slot] <= upd;
    end
    if (accept) begin
      rd_data  <= store[item.slot];
      b_item   <= item;
      fwd_hit  <= fire && (b_item.slot == item.slot);
      fwd_data <= upd;
    end
  end

endmodule

### src/mp2a_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the max pooling block, attached by a bind statement.
// Depends on mp2a_pkg and on the top level max_pool_2d_argmax.
module mp2a_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   res_valid,
  input logic                                   res_ready,
  input logic signed [mp2a_pkg::SAMPLE_BITS-1:0] res_pooled,
  input logic [mp2a_pkg::POS_BITS-1:0]           res_out_row,
  input logic [mp2a_pkg::POS_BITS-1:0]           res_out_col,
  input logic [mp2a_pkg::POS_BITS-1:0]           res_winner_row,
  input logic [mp2a_pkg::POS_BITS-1:0]           res_winner_col
);

  // A stalled result word keeps its value until taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_pooled) &&
      $stable(res_winner_row) && $stable(res_winner_col))
    else $error("result word changed while stalled");

  // The winner lies inside its window, which starts at or beyond the
  // output position times a window size of at least one.
  a_winner: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_winner_row >= res_out_row) && (res_winner_col >= res_out_col))
    else $error("winner position lies before its window");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid straight after reset");

endmodule

bind max_pool_2d_argmax mp2a_checker u_mp2a_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (results.valid),
  .res_ready      (results.ready),
  .res_pooled     (results.pooled),
  .res_out_row    (results.out_row),
  .res_out_col    (results.out_col),
  .res_winner_row (results.winner_row),
  .res_winner_col (results.winner_col)
);

### tb/tb_max_pool_2d_argmax.sv
`timescale 1ns / 1ps
// Self-checking testbench for the streaming 2-D max pooling block with argmax.
// Depends on mp2a_pkg, the channel interfaces in mp2a_if and max_pool_2d_argmax.
module tb_max_pool_2d_argmax;
  import mp2a_pkg::*;

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;
  typedef logic [CFG_DATA_BITS-1:0]      cfg_word_t;

  // Results leave through the update stage and an output register, so a handful
  // of quiet cycles is ample before the block can be taken as idle.
  localparam int   SETTLE_CYCLES = 8;
  localparam int   RANDOM_TARGET = 1200;
  localparam int   REPORT_LIMIT  = 50;
  localparam smp_t S_MAX         = 16'sh7fff;
  localparam smp_t S_MIN         = 16'sh8000;

  logic      clk      = 1'b0;
  logic      rst      = 1'b1;
  logic      wr_en    = 1'b0;
  cfg_reg_t  wr_index = REG_WINDOW_ROWS;
  cfg_word_t wr_data  = '0;

  mp2a_sample_if samples_ch ();
  mp2a_result_if results_ch ();

  max_pool_2d_argmax uut (
    .clk      (clk),
    .rst      (rst),
    .samples  (samples_ch),
    .results  (results_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // Stimulus and scoreboard bookkeeping.
  smp_t    sample_feed[$];
  result_t pooled_due[$];
  int      samples_queued = 0;
  int      samples_taken  = 0;
  int      words_checked  = 0;
  int      maps_closed    = 0;
  int      phase_count    = 0;
  int      errors         = 0;
  int      src_gap_pct    = 0;
  int      snk_stall_pct  = 0;

  // Local copy of the pooling state: the active settings, the per-column
  // running maximum with its winner offset, and the stream position.
  int unsigned                win_h, win_w, map_h, map_w;
  smp_t                       col_best [MAX_OUT_COLS];
  logic [OFF_BITS-1:0]        best_dr  [MAX_OUT_COLS];
  logic [OFF_BITS-1:0]        best_dc  [MAX_OUT_COLS];
  int unsigned                next_row, next_col, in_win_row, in_win_col;

  // ---------------------------------------------------------------------------
  // Clock, reset and the values every input holds from time zero.
  // ---------------------------------------------------------------------------
  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    samples_ch.valid  = 1'b0;
    samples_ch.sample = '0;
    results_ch.ready  = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // Safety net: the slowest correct run is a small fraction of this.
  initial begin
    #2_000_000;
    $display("tb_max_pool_2d_argmax NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor.
  // ---------------------------------------------------------------------------

  // Returns the stream to the first sample of a map.
  function automatic void rewind_stream();
    next_row   = 0;
    next_col   = 0;
    in_win_row = 0;
    in_win_col = 0;
  endfunction

  // A setting write clamps the value into its legal range; the window
  // registers see only the low five bits of the data word.
  function automatic void load_setting(cfg_reg_t idx, cfg_word_t val);
    int unsigned w, m;
    w = val[WIN_REG_BITS-1:0];
    m = val[MAP_REG_BITS-1:0];
    if (w < 1) w = 1;
    if (w > MAX_WINDOW) w = MAX_WINDOW;
    if (m < 1) m = 1;
    if (m > MAP_LIMIT) m = MAP_LIMIT;
    case (idx)
      REG_WINDOW_ROWS: win_h = w;
      REG_WINDOW_COLS: win_w = w;
      REG_IN_ROWS:     map_h = m;
      REG_IN_COLS:     map_w = m;
      default: ;
    endcase
    rewind_stream();
  endfunction

  // Folds one sample into its window and returns 1 with the pooled word when
  // the sample closes the window. The first sample of a window always opens
  // the store entry; later ones replace it only when strictly greater, so the
  // first largest sample in raster order keeps the win.
  function automatic bit pool_step(input smp_t s, output result_t res);
    int unsigned r, c, oc, slot;
    bit          last_r, last_c, closes;
    r      = next_row;
    c      = next_col;
    oc     = c / win_w;
    slot   = oc % MAX_OUT_COLS;
    last_r = (r + 1 >= map_h);
    last_c = (c + 1 >= map_w);
    if (in_win_row == 0 && in_win_col == 0) begin
      col_best[slot] = s;
      best_dr[slot]  = '0;
      best_dc[slot]  = '0;
    end else if (s > col_best[slot]) begin
      col_best[slot] = s;
      best_dr[slot]  = OFF_BITS'(in_win_row);
      best_dc[slot]  = OFF_BITS'(in_win_col);
    end
    // Clipped windows at the right and bottom edges close on the map edge.
    closes = (in_win_row + 1 >= win_h || last_r) && (in_win_col + 1 >= win_w || last_c);
    res = '0;
    if (closes) begin
      res.pooled     = col_best[slot];
      res.out_row    = POS_BITS'(r / win_h);
      res.out_col    = POS_BITS'(oc);
      res.winner_row = POS_BITS'(r - in_win_row + best_dr[slot]);
      res.winner_col = POS_BITS'(c - in_win_col + best_dc[slot]);
      res.map_done   = last_r && last_c;
    end
    if (last_c) begin
      next_col   = 0;
      in_win_col = 0;
      if (last_r) begin
        next_row   = 0;
        in_win_row = 0;
      end else begin
        next_row   = r + 1;
        in_win_row = (in_win_row + 1 >= win_h) ? 0 : in_win_row + 1;
      end
    end else begin
      next_col   = c + 1;
      in_win_col = (in_win_col + 1 >= win_w) ? 0 : in_win_col + 1;
    end
    return closes;
  endfunction

  initial begin
    win_h = 2;
    win_w = 2;
    map_h = 28;
    map_w = 28;
    rewind_stream();
  end

  // ---------------------------------------------------------------------------
  // Sample driver: presents the next queued word, holding it until taken, and
  // idles at random according to the current gap percentage.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      samples_ch.valid <= 1'b0;
    end else if (!samples_ch.valid || samples_ch.ready) begin
      if (sample_feed.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
        samples_ch.valid  <= 1'b1;
        samples_ch.sample <= sample_feed.pop_front();
      end else begin
        samples_ch.valid <= 1'b0;
      end
    end
  end

  // Every accepted sample goes through the predictor straight away; the
  // pooled word it closes, if any, joins the back of the expected queue.
  always @(posedge clk) begin : take_sample
    result_t res;
    if (!rst && samples_ch.valid && samples_ch.ready) begin
      if (pool_step(samples_ch.sample, res)) begin
        pooled_due.push_back(res);
      end
      samples_taken++;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and a field-by-field comparison of each
  // accepted word against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      results_ch.ready <= 1'b0;
    end else begin
      results_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      if (errors < REPORT_LIMIT) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
      errors++;
    end
  endfunction

  always @(posedge clk) begin : check_result
    result_t want;
    if (!rst && results_ch.valid && results_ch.ready) begin
      if (pooled_due.size() == 0) begin
        if (errors < REPORT_LIMIT) begin
          $display("%0t: unexpected pooled word, expected none, got %0d at (%0d,%0d)",
                   $time, results_ch.pooled, results_ch.out_row, results_ch.out_col);
        end
        errors++;
      end else begin
        want = pooled_due.pop_front();
        check_field("pooled", want.pooled, results_ch.pooled);
        check_field("out_row", want.out_row, results_ch.out_row);
        check_field("out_col", want.out_col, results_ch.out_col);
        check_field("winner_row", want.winner_row, results_ch.winner_row);
        check_field("winner_col", want.winner_col, results_ch.winner_col);
        check_field("map_done", want.map_done, results_ch.map_done);
        if (want.map_done) maps_closed++;
        words_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // The block is idle once every queued sample has been taken, every expected
  // word has arrived, and a few more cycles have passed for any sample that
  // closed no window but may still sit in the pipeline.
  task automatic wait_idle();
    while (samples_taken != samples_queued || pooled_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(cfg_reg_t idx, cfg_word_t val);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    load_setting(idx, val);
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic set_all(cfg_word_t wh, cfg_word_t ww, cfg_word_t mh, cfg_word_t mw);
    set_reg(REG_WINDOW_ROWS, wh);
    set_reg(REG_WINDOW_COLS, ww);
    set_reg(REG_IN_ROWS, mh);
    set_reg(REG_IN_COLS, mw);
  endtask

  task automatic send_words(input smp_t words[$]);
    foreach (words[i]) sample_feed.push_back(words[i]);
    samples_queued += words.size();
    wait_idle();
    phase_count++;
  endtask

  // Mostly full-range values, with a share of extremes and of small values
  // close together so that ties inside a window are common.
  function automatic smp_t pick_sample();
    case ($urandom_range(9))
      0:       return S_MAX;
      1:       return S_MIN;
      2, 3:    return smp_t'(int'($urandom_range(3)) - 2);
      default: return smp_t'($urandom());
    endcase
  endfunction

  task automatic run_random(int n);
    smp_t words[$];
    repeat (n) words.push_back(pick_sample());
    send_words(words);
  endtask

  // Raw window values include zero and values above the limit, which the
  // block clamps; only the low five bits of the word count.
  function automatic cfg_word_t pick_window();
    case ($urandom_range(19))
      0:       return '0;
      1:       return cfg_word_t'($urandom_range(17, 2047));
      2:       return cfg_word_t'(MAX_WINDOW);
      3, 4:    return cfg_word_t'($urandom_range(5, 15));
      default: return cfg_word_t'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic cfg_word_t pick_dim();
    case ($urandom_range(19))
      0:       return '0;
      1:       return cfg_word_t'(MAP_LIMIT);
      2:       return cfg_word_t'($urandom_range(1025, 2047));
      3, 4:    return cfg_word_t'($urandom_range(13, 40));
      default: return cfg_word_t'($urandom_range(1, 12));
    endcase
  endfunction

  // One random phase: new settings on some or all registers, then whole maps
  // with random content, now and then broken off part way through a map.
  // Maps too large to finish are sent as a partial stream only.
  task automatic random_phase();
    bit [3:0]    mask;
    int unsigned area;
    int          n;
    mask = ($urandom_range(2) == 0) ? 4'hF : 4'($urandom_range(1, 15));
    if (mask[0]) set_reg(REG_WINDOW_ROWS, pick_window());
    if (mask[1]) set_reg(REG_WINDOW_COLS, pick_window());
    if (mask[2]) set_reg(REG_IN_ROWS, pick_dim());
    if (mask[3]) set_reg(REG_IN_COLS, pick_dim());
    area = map_h * map_w;
    if (area <= 150) begin
      n = area * $urandom_range(1, (150 / area > 1) ? 150 / area : 1);
      if ($urandom_range(4) == 0) n += $urandom_range(1, area);
    end else begin
      n = $urandom_range(40, 160);
    end
    run_random(n);
  endtask

  // Idling schedule: the sender gaps lightly while the receiver stalls
  // heavily, then the reverse, then both sides run flat out.
  task automatic pick_idle_mode();
    if (samples_queued < RANDOM_TARGET / 3) begin
      src_gap_pct   = 15;
      snk_stall_pct = 67;
    end else if (samples_queued < 2 * RANDOM_TARGET / 3) begin
      src_gap_pct   = 67;
      snk_stall_pct = 15;
    end else begin
      src_gap_pct   = 0;
      snk_stall_pct = 0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    wait (!rst);
    @(posedge clk);
    pick_idle_mode();

    // Two-by-two windows on a three-by-three map, so both edges clip. The
    // first window holds both extremes and a tie on the largest value, which
    // the earlier sample must win; the bottom row is all the most negative
    // value, so the first sample of the clipped window wins on equality.
    set_all(2, 2, 3, 3);
    send_words('{S_MAX, S_MIN, 0, S_MAX, -1, S_MIN, S_MIN, S_MIN, S_MIN});

    // Zero window height and zero map height clamp to one; a window width of
    // thirty-one clamps to sixteen, wider than the five-column map.
    set_all(0, 31, 0, 5);
    send_words('{-5, 7, 7, 3, 7});

    // One-by-one windows on a single-sample map: every word closes a map.
    set_reg(REG_WINDOW_COLS, 1);
    set_reg(REG_IN_COLS, 1);
    send_words('{S_MAX, S_MIN});

    // Map sizes above the limit clamp to the largest map; these samples
    // close no window and the next write restarts the stream anyway.
    set_all(16, 2047, 2047, 1024);
    send_words('{16'sh5555, 16'shaaaa, S_MIN, S_MAX});

    // Full-height windows with a clipped lower band, tall single-column maps
    // and one very wide single-row map, each with random content.
    set_all(16, 2, 17, 3);
    run_random(51);
    set_all(0, 1, 1024, 1);
    run_random(100);
    set_all(1, 16, 1, 2047);
    run_random(100);

    while (samples_queued < RANDOM_TARGET) begin
      pick_idle_mode();
      random_phase();
    end

    wait_idle();
    $display("Ran %0d phases, %0d samples in, %0d pooled words checked.",
             phase_count, samples_taken, words_checked);
    $display("%0d of those words closed a whole map.", maps_closed);
    if (errors == 0 && pooled_due.size() == 0) begin
      $display("tb_max_pool_2d_argmax OK");
    end else begin
      $display("tb_max_pool_2d_argmax NOT OK");
    end
    $finish;
  end

endmodule

### files.f
src/mp2a_pkg.sv
src/mp2a_if.sv
src/mp2a_update.sv
src/max_pool_2d_argmax.sv
src/mp2a_checker.sv
tb/tb_max_pool_2d_argmax.sv
